>>> src/cnlm_pkg.sv
// Shared types, phase codes and character constants of the numeric literal matcher.
package cnlm_pkg;

    // Saturation limit of the character count and the derived count width.
    localparam int unsigned MAX_LEN = 65535;
    localparam int CNT_W   = $clog2(MAX_LEN + 1);
    localparam int CHAR_W  = 21;
    localparam int LEN_W   = 16;
    localparam int PHASE_W = 4;

    typedef logic [CHAR_W-1:0]  t_char;
    typedef logic [CNT_W-1:0]   t_count;
    typedef logic [LEN_W-1:0]   t_len;
    typedef logic [PHASE_W-1:0] t_phase;

    localparam t_count CNT_MAX = t_count'(MAX_LEN);

    // Scan phase codes.
    localparam t_phase PH_START    = 4'd0;
    localparam t_phase PH_DOT      = 4'd1;
    localparam t_phase PH_ZERO     = 4'd2;
    localparam t_phase PH_HEX_PRE  = 4'd3;
    localparam t_phase PH_HEX_DIG  = 4'd4;
    localparam t_phase PH_BIN_PRE  = 4'd5;
    localparam t_phase PH_BIN_DIG  = 4'd6;
    localparam t_phase PH_INT      = 4'd7;
    localparam t_phase PH_FRAC     = 4'd8;
    localparam t_phase PH_EXP_E    = 4'd9;
    localparam t_phase PH_EXP_SIGN = 4'd10;
    localparam t_phase PH_EXP_DIG  = 4'd11;
    localparam t_phase PH_SUFFIX   = 4'd12;

    // Character codes.
    localparam t_char CH_0      = 21'h30;
    localparam t_char CH_1      = 21'h31;
    localparam t_char CH_9      = 21'h39;
    localparam t_char CH_A_LO   = 21'h61;
    localparam t_char CH_F_LO   = 21'h66;
    localparam t_char CH_A_UP   = 21'h41;
    localparam t_char CH_F_UP   = 21'h46;
    localparam t_char CH_X_LO   = 21'h78;
    localparam t_char CH_X_UP   = 21'h58;
    localparam t_char CH_B_LO   = 21'h62;
    localparam t_char CH_B_UP   = 21'h42;
    localparam t_char CH_E_LO   = 21'h65;
    localparam t_char CH_E_UP   = 21'h45;
    localparam t_char CH_DOT    = 21'h2e;
    localparam t_char CH_PLUS   = 21'h2b;
    localparam t_char CH_MINUS  = 21'h2d;
    localparam t_char CH_SEP    = 21'h27;
    localparam t_char CH_U_LO   = 21'h75;
    localparam t_char CH_U_UP   = 21'h55;
    localparam t_char CH_L_LO   = 21'h6c;
    localparam t_char CH_L_UP   = 21'h4c;
    localparam t_char CH_Z_LO   = 21'h7a;
    localparam t_char CH_Z_UP   = 21'h5a;

    // Scanner state carried from one character to the next.
    typedef struct packed {
        t_phase phase;
        t_count count;
        t_count emark;
        logic   given;
    } t_scan_state;

    localparam t_scan_state SCAN_RESET = '{
        phase: PH_START, count: '0, emark: '0, given: 1'b0};

    // Outcome of one character step.
    typedef struct packed {
        logic produce;
        t_len length;
    } t_step_result;

endpackage

>>> src/cnlm_if.sv
// Valid/ready channel interfaces for characters in and literal lengths out.
interface cnlm_char_if;
    import cnlm_pkg::*;

    logic  valid;
    logic  ready;
    t_char char_code;
    logic  first_of_text;
    logic  last_of_text;

    modport source (output valid, output char_code, output first_of_text,
                    output last_of_text, input ready);
    modport sink   (input valid, input char_code, input first_of_text,
                    input last_of_text, output ready);
endinterface

interface cnlm_len_if;
    import cnlm_pkg::*;

    logic valid;
    logic ready;
    t_len match_length;

    modport source (output valid, output match_length, input ready);
    modport sink   (input valid, input match_length, output ready);
endinterface

>>> src/cnlm_step.sv
// Next-state and result logic for one character of the literal scan.
module cnlm_step (
    input  cnlm_pkg::t_scan_state  i_state,
    input  cnlm_pkg::t_char        i_char_code,
    input  logic                   i_first,
    input  logic                   i_last,
    output cnlm_pkg::t_scan_state  o_next,
    output cnlm_pkg::t_step_result o_result
);
    import cnlm_pkg::*;

    t_scan_state eff;
    t_scan_state adv;
    t_phase      nphase;
    logic        acc;
    logic        set_mark;
    logic        c_dec, c_hex, c_bin, c_sep, c_suf, c_exp, c_sign, c_x, c_b, c_dot;
    t_count      fin_len;

    function automatic t_len to_len(input t_count c);
        logic [CNT_W+LEN_W-1:0] w;
        w = {{LEN_W{1'b0}}, c};
        return w[LEN_W-1:0];
    endfunction

    // Character classes.
    assign c_dec  = (i_char_code >= CH_0) && (i_char_code <= CH_9);
    assign c_hex  = c_dec || ((i_char_code >= CH_A_LO) && (i_char_code <= CH_F_LO))
                          || ((i_char_code >= CH_A_UP) && (i_char_code <= CH_F_UP));
    assign c_bin  = (i_char_code == CH_0) || (i_char_code == CH_1);
    assign c_sep  = (i_char_code == CH_SEP);
    assign c_suf  = (i_char_code == CH_U_LO) || (i_char_code == CH_U_UP) ||
                    (i_char_code == CH_L_LO) || (i_char_code == CH_L_UP) ||
                    (i_char_code == CH_F_LO) || (i_char_code == CH_F_UP) ||
                    (i_char_code == CH_Z_LO) || (i_char_code == CH_Z_UP);
    assign c_exp  = (i_char_code == CH_E_LO) || (i_char_code == CH_E_UP);
    assign c_sign = (i_char_code == CH_PLUS) || (i_char_code == CH_MINUS);
    assign c_x    = (i_char_code == CH_X_LO) || (i_char_code == CH_X_UP);
    assign c_b    = (i_char_code == CH_B_LO) || (i_char_code == CH_B_UP);
    assign c_dot  = (i_char_code == CH_DOT);

    // A new text restarts the scan before this character is examined.
    assign eff = i_first ? SCAN_RESET : i_state;

    // Phase transition for the current character.
    always_comb begin
        nphase   = eff.phase;
        acc      = 1'b0;
        set_mark = 1'b0;
        unique case (eff.phase) inside
            PH_START: begin
                if (i_char_code == CH_0) begin
                    nphase = PH_ZERO; acc = 1'b1;
                end else if (c_dec) begin
                    nphase = PH_INT; acc = 1'b1;
                end else if (c_dot) begin
                    nphase = PH_DOT; acc = 1'b1;
                end
            end
            PH_DOT: begin
                if (c_dec) begin
                    nphase = PH_FRAC; acc = 1'b1;
                end
            end
            PH_ZERO, PH_INT: begin
                if (eff.phase == PH_ZERO && c_x) begin
                    nphase = PH_HEX_PRE; acc = 1'b1;
                end else if (eff.phase == PH_ZERO && c_b) begin
                    nphase = PH_BIN_PRE; acc = 1'b1;
                end else if (c_dec || c_sep) begin
                    nphase = PH_INT; acc = 1'b1;
                end else if (c_dot) begin
                    nphase = PH_FRAC; acc = 1'b1;
                end else if (c_exp) begin
                    nphase = PH_EXP_E; acc = 1'b1; set_mark = 1'b1;
                end else if (c_suf) begin
                    nphase = PH_SUFFIX; acc = 1'b1;
                end
            end
            PH_FRAC: begin
                if (c_dec || c_sep) begin
                    nphase = PH_FRAC; acc = 1'b1;
                end else if (c_exp) begin
                    nphase = PH_EXP_E; acc = 1'b1; set_mark = 1'b1;
                end else if (c_suf) begin
                    nphase = PH_SUFFIX; acc = 1'b1;
                end
            end
            PH_HEX_PRE, PH_HEX_DIG: begin
                if (c_hex || c_sep) begin
                    nphase = PH_HEX_DIG; acc = 1'b1;
                end else if (eff.phase == PH_HEX_DIG && c_suf) begin
                    nphase = PH_SUFFIX; acc = 1'b1;
                end
            end
            PH_BIN_PRE, PH_BIN_DIG: begin
                if (c_bin || c_sep) begin
                    nphase = PH_BIN_DIG; acc = 1'b1;
                end else if (eff.phase == PH_BIN_DIG && c_suf) begin
                    nphase = PH_SUFFIX; acc = 1'b1;
                end
            end
            PH_EXP_E, PH_EXP_SIGN: begin
                if (eff.phase == PH_EXP_E && c_sign) begin
                    nphase = PH_EXP_SIGN; acc = 1'b1;
                end else if (c_dec) begin
                    nphase = PH_EXP_DIG; acc = 1'b1;
                end
            end
            PH_EXP_DIG: begin
                if (c_dec) begin
                    nphase = PH_EXP_DIG; acc = 1'b1;
                end else if (c_suf) begin
                    nphase = PH_SUFFIX; acc = 1'b1;
                end
            end
            PH_SUFFIX: begin
                if (c_suf) begin
                    nphase = PH_SUFFIX; acc = 1'b1;
                end
            end
            default: begin
                acc = 1'b0;
            end
        endcase
    end

    // State after the character is taken, with a saturating count.
    always_comb begin
        adv = eff;
        if (acc) begin
            adv.phase = nphase;
            if (eff.count < CNT_MAX) begin
                adv.count = t_count'(eff.count + 1'b1);
            end
            if (set_mark) begin
                adv.emark = eff.count;
            end
        end
    end

    // Length if the text ended after this character.
    always_comb begin
        unique case (adv.phase) inside
            PH_START, PH_DOT, PH_HEX_PRE, PH_BIN_PRE: fin_len = '0;
            PH_EXP_E, PH_EXP_SIGN:                   fin_len = adv.emark;
            default:                                 fin_len = adv.count;
        endcase
    end

    // Result and next state; a last character always leaves the scan at start of text.
    always_comb begin
        o_result.produce = !eff.given && (!acc || i_last);
        o_result.length  = to_len(fin_len);
        if (i_last) begin
            o_next = SCAN_RESET;
        end else if (eff.given) begin
            o_next = eff;
        end else begin
            o_next       = adv;
            o_next.given = o_result.produce;
        end
    end

endmodule

>>> src/cpp_number_literal_matcher.sv
// Top level of the C++ numeric literal length matcher.
//
// Characters of a text arrive on i_char, one per transfer, with first_of_text
// and last_of_text marking text bounds. For each text the block sends one
// match_length transfer on o_len: on the first character that cannot extend
// the literal, or on the last character of the text. Characters after that
// result are consumed without output until the next text begins.
// An accepted character lands in the input register and is scanned from there;
// its result, if any, is then written to the output register, which drives
// o_len.valid. Throughput: one character per cycle while no result is held
// back by a pending one; the scan state is one short step of compare and
// increment logic between the input register and the state.
// A pending result in the output register does not block the input register;
// while the receiver stalls with a result pending, characters that cause no
// result still pass, and the scan holds only on a character that would
// produce a second result. Reset clears both valid flags and returns the
// scan to the start of a text with a zero count.
module cpp_number_literal_matcher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cnlm_char_if.sink   i_char,
    cnlm_len_if.source  o_len
);
    import cnlm_pkg::*;

    logic         r_in_valid;
    t_char        r_in_char;
    logic         r_in_first;
    logic         r_in_last;
    t_scan_state  r_state;
    t_scan_state  n_state;
    t_step_result step_res;
    logic         r_out_valid;
    t_len         r_out_len;
    logic         out_free;
    logic         advance;

    cnlm_step u_step (
        .i_state     (r_state),
        .i_char_code (r_in_char),
        .i_first     (r_in_first),
        .i_last      (r_in_last),
        .o_next      (n_state),
        .o_result    (step_res)
    );

    // The held character moves on unless its result would collide with a pending one.
    assign out_free     = !r_out_valid || o_len.ready;
    assign advance      = r_in_valid && (!step_res.produce || out_free);
    assign i_char.ready = !r_in_valid || advance;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_char.ready) begin
            r_in_valid <= i_char.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_char.valid && i_char.ready) begin
            r_in_char  <= i_char.char_code;
            r_in_first <= i_char.first_of_text;
            r_in_last  <= i_char.last_of_text;
        end
    end

    // Scan state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SCAN_RESET;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && step_res.produce) begin
            r_out_valid <= 1'b1;
        end else if (o_len.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && step_res.produce) begin
            r_out_len <= step_res.length;
        end
    end

    assign o_len.valid        = r_out_valid;
    assign o_len.match_length = r_out_len;

    // A last character returns the scan to the start of a text.
    a_last_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_in_last) |=>
            (r_state.phase == PH_START && !r_state.given && r_state.count == '0))
        else $error("scan not restarted after last character");

    // The result flag only rises on a step that delivered a result.
    a_given_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_state.given) |-> $past(advance && step_res.produce))
        else $error("result flag set without a result");

    // The count saturates at the limit.
    a_count_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.count <= CNT_MAX)
        else $error("character count above limit");

    // The exponent mark is a count taken earlier in the same text.
    a_mark_le_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.emark <= r_state.count)
        else $error("exponent mark beyond count");

endmodule
